FILE: hw/rtl/selective_ack_window_tracker_top_assert.svh
// Assertion macros for the selective-ack window tracker.
// Expects i_clk and i_rst_n in the scope of the module that includes it.
`ifndef SELECTIVE_ACK_WINDOW_TRACKER_TOP_ASSERT_SVH
`define SELECTIVE_ACK_WINDOW_TRACKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAWT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAWT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sawt_pkg.sv
// Shared types and constants for the selective-ack window tracker.
// No dependencies.
package sawt_pkg;

    localparam int unsigned DEFAULT_WINDOW_SIZE = 64;
    localparam int unsigned SEQ_W               = 32;
    localparam int unsigned ACK_BITS_W          = 32;

    typedef logic [SEQ_W-1:0] t_seq;

    // Header facts of one datagram that travel with its sequence number.
    typedef struct packed {
        logic reliable;
        logic ack_only;
        logic has_payload;
    } t_hdr_flags;

    // Per-item status produced by the window update.
    typedef struct packed {
        logic recorded;
        logic out_of_window;
    } t_upd_flags;

endpackage

FILE: hw/rtl/selective_ack_window_tracker_top.sv
// Selective-ack receive window tracker. Each item carries the parsed header
// facts of one datagram; each accepted item yields exactly one result with
// the cumulative ack, the 32 ack bits above it and two status flags. Each
// item passes the input register, then the result register, and one item is
// taken every cycle unless the result channel stalls; the window update marks
// the sequence, counts the run of received bits and shifts the window in a
// single combinational pass between those registers. There are no configuration
// registers. Depends on sawt_pkg, sawt_update and the assertion macro header.
module selective_ack_window_tracker_top #(
    parameter int unsigned WINDOW_SIZE = sawt_pkg::DEFAULT_WINDOW_SIZE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sawt_pkg::t_seq        i_seq,
    input  logic                  i_reliable,
    input  logic                  i_ack_only,
    input  logic                  i_has_payload,
    // Result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output sawt_pkg::t_seq        o_cum_ack,
    output logic [sawt_pkg::ACK_BITS_W-1:0] o_ack_bits,
    output logic                  o_recorded,
    output logic                  o_out_of_window
);
    import sawt_pkg::*;

    `include "selective_ack_window_tracker_top_assert.svh"

    // Input register
    logic       r_in_vld;
    t_seq       r_in_seq;
    t_hdr_flags r_in_hdr;

    // Receive state
    t_seq                   r_cum;
    logic [WINDOW_SIZE-1:0] r_win;

    // Result register
    logic                  r_out_vld;
    t_seq                  r_out_cum;
    logic [ACK_BITS_W-1:0] r_out_bits;
    t_upd_flags            r_out_flags;

    t_seq                   n_cum;
    logic [WINDOW_SIZE-1:0] n_win;
    t_upd_flags             n_flags;

    logic w_out_free;
    logic w_adv;

    assign w_out_free = !r_out_vld || !i_stall;
    assign w_adv      = r_in_vld && w_out_free;
    assign o_stall    = r_in_vld && !w_out_free;

    sawt_update #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_update (
        .i_seq     (r_in_seq),
        .i_hdr     (r_in_hdr),
        .i_cum_ack (r_cum),
        .i_win     (r_win),
        .o_cum_ack (n_cum),
        .o_win     (n_win),
        .o_flags   (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cum     <= '0;
            r_win     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (w_out_free) begin
                r_out_vld <= r_in_vld;
            end
            // State moves only when the item in the input register retires,
            // so the next item always sees the updated window.
            if (w_adv) begin
                r_cum <= n_cum;
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_seq             <= i_seq;
            r_in_hdr.reliable    <= i_reliable;
            r_in_hdr.ack_only    <= i_ack_only;
            r_in_hdr.has_payload <= i_has_payload;
        end
        if (w_adv) begin
            r_out_cum   <= n_cum;
            r_out_bits  <= n_win[ACK_BITS_W-1:0];
            r_out_flags <= n_flags;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_cum_ack       = r_out_cum;
    assign o_ack_bits      = r_out_bits;
    assign o_recorded      = r_out_flags.recorded;
    assign o_out_of_window = r_out_flags.out_of_window;

    // The bottom bit of the window is always consumed by the ack advance.
    `SAWT_ASSERT_NOW(a_win_bottom_clear, 1'b1, r_win[0] == 1'b0,
        "window bit for the next expected sequence is set")

    `SAWT_ASSERT_NEXT(a_cum_monotonic, 1'b1, r_cum >= $past(r_cum),
        "cumulative ack moved backward")

    `SAWT_ASSERT_NEXT(a_state_hold, !w_adv, $stable(r_cum) && $stable(r_win),
        "receive state changed without an item retiring")

    `SAWT_ASSERT_NOW(a_flags_exclusive, r_out_vld,
        !(r_out_flags.recorded && r_out_flags.out_of_window),
        "item both recorded and flagged out of window")

endmodule

FILE: hw/rtl/sawt_update.sv
// Combinational next-state logic of the receive window: marks one sequence,
// then advances the cumulative ack over the run of received bits.
// Depends on sawt_pkg.
module sawt_update #(
    parameter int unsigned WINDOW_SIZE = sawt_pkg::DEFAULT_WINDOW_SIZE
) (
    input  sawt_pkg::t_seq        i_seq,
    input  sawt_pkg::t_hdr_flags  i_hdr,
    input  sawt_pkg::t_seq        i_cum_ack,
    input  logic [WINDOW_SIZE-1:0] i_win,
    output sawt_pkg::t_seq        o_cum_ack,
    output logic [WINDOW_SIZE-1:0] o_win,
    output sawt_pkg::t_upd_flags  o_flags
);
    import sawt_pkg::*;

    localparam int unsigned POS_W = $clog2(WINDOW_SIZE);
    localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam t_seq        WIN_SEQ = t_seq'(WINDOW_SIZE);

    logic                   w_take;
    t_seq                   w_delta;
    logic                   w_in_win;
    logic [POS_W-1:0]       w_pos;
    logic [WINDOW_SIZE-1:0] w_mark;
    logic [WINDOW_SIZE-1:0] w_set_win;
    logic [CNT_W-1:0]       w_run;

    always_comb begin
        w_take = !i_hdr.ack_only && i_hdr.has_payload && (i_seq != '0)
                 && i_hdr.reliable && (i_seq > i_cum_ack);
        w_delta  = i_seq - i_cum_ack;
        w_in_win = w_take && (w_delta <= WIN_SEQ);
        w_pos    = POS_W'(w_delta - t_seq'(1));

        w_mark = '0;
        if (w_in_win) begin
            w_mark[w_pos] = 1'b1;
        end
        w_set_win = i_win | w_mark;

        // Length of the run of ones at the bottom: position of the lowest zero.
        w_run = CNT_W'(WINDOW_SIZE);
        for (int i = WINDOW_SIZE - 1; i >= 0; i--) begin
            if (!w_set_win[i]) begin
                w_run = CNT_W'(i);
            end
        end

        o_win     = w_set_win >> w_run;
        o_cum_ack = i_cum_ack + t_seq'(w_run);

        o_flags.recorded      = w_in_win && !i_win[w_pos];
        o_flags.out_of_window = w_take && !w_in_win;
    end

endmodule
